FILE: hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the banker's safety checker: the request and
// result payloads, request kinds, the sequencer states and lane commands.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int AMT_W     = 8;
    localparam int RANK_W    = 3;
    localparam int PROC_W    = 2;
    localparam int MAX_RES   = 3;
    localparam int MAX_PROCS = 4;

    typedef enum logic [1:0] {
        KIND_ROW   = 2'd0,
        KIND_AVAIL = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_REQ   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ,
        ST_START,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [PROC_W-1:0]  proc;
        logic [AMT_W-1:0]   amount_0;
        logic [AMT_W-1:0]   amount_1;
        logic [AMT_W-1:0]   amount_2;
        logic [AMT_W-1:0]   claim_0;
        logic [AMT_W-1:0]   claim_1;
        logic [AMT_W-1:0]   claim_2;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic               safe;
        logic [RANK_W-1:0]  rank_0;
        logic [RANK_W-1:0]  rank_1;
        logic [RANK_W-1:0]  rank_2;
        logic [RANK_W-1:0]  rank_3;
    } rsp_t;

    typedef struct packed {
        logic wr_row;
        logic wr_avail;
        logic latch_req;
        logic apply_req;
        logic load_work;
        logic add_work;
    } lane_cmd_t;

endpackage

FILE: hdl/bsc_if.sv
// ----------------------------------------------------------------------------
// bsc_if
// Valid/ready channels that carry requests into and results out of the
// banker's safety checker.
// ----------------------------------------------------------------------------
interface bsc_req_if import bsc_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsc_rsp_if import bsc_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bsc_lane.sv
// ----------------------------------------------------------------------------
// bsc_lane
// One resource lane: holds the allocation and claim column and the available
// count of its resource, the working count of a safety check, and compares
// the need of the addressed process row against it and a latched request against its available count.
// ----------------------------------------------------------------------------
module bsc_lane
    import bsc_pkg::*;
#(
    parameter int PROCS  = 4,
    parameter int WORK_W = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_cmd_t                  cmd,
    input  logic [$clog2(PROCS)-1:0]   idx,
    input  logic [AMT_W-1:0]           amt,
    input  logic [AMT_W-1:0]           clm,
    output logic                       fits,
    output logic                       req_ok
);

    logic [AMT_W-1:0]  alloc_reg [PROCS];
    logic [AMT_W-1:0]  claim_reg [PROCS];
    logic [AMT_W-1:0]  avail_reg;
    logic [AMT_W-1:0]  amt_reg;
    logic [WORK_W-1:0] work_reg;
    logic [WORK_W-1:0] work_next;

    logic [AMT_W-1:0]  row_alloc;
    logic [AMT_W-1:0]  row_claim;
    logic [AMT_W-1:0]  need;
    logic [AMT_W:0]    alloc_sum;

    assign row_alloc = alloc_reg[idx];
    assign row_claim = claim_reg[idx];
    assign need      = (row_claim > row_alloc) ? (row_claim - row_alloc) : '0;
    assign fits      = WORK_W'(need) <= work_reg;
    assign alloc_sum = {1'b0, row_alloc} + {1'b0, amt_reg};
    assign req_ok    = (amt_reg <= avail_reg) && !alloc_sum[AMT_W];

    always_comb
    begin
        work_next = work_reg;
        if (cmd.load_work)
        begin
            work_next = WORK_W'(avail_reg);
        end
        else if (cmd.add_work)
        begin
            work_next = work_reg + WORK_W'(row_alloc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PROCS; p++)
            begin
                alloc_reg[p] <= '0;
                claim_reg[p] <= '0;
            end
            avail_reg <= '0;
        end
        else
        begin
            if (cmd.wr_row)
            begin
                alloc_reg[idx] <= amt;
                claim_reg[idx] <= clm;
            end
            else if (cmd.apply_req)
            begin
                alloc_reg[idx] <= alloc_sum[AMT_W-1:0];
            end
            if (cmd.wr_avail)
            begin
                avail_reg <= amt;
            end
            else if (cmd.apply_req)
            begin
                avail_reg <= avail_reg - amt_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (cmd.latch_req)
        begin
            amt_reg <= amt;
        end
    end

endmodule

FILE: hdl/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer and merge stage: decodes requests, steers the lanes, combines
// the lane fit flags per process row, and keeps the finish ranks.
// ----------------------------------------------------------------------------
module bsc_ctrl
    import bsc_pkg::*;
#(
    parameter int PROCS = 4,
    parameter int RES   = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  req_t                       in_data,
    output logic                       in_ready,
    input  logic [RES-1:0]             fits_vec,
    input  logic [RES-1:0]             ok_vec,
    input  logic                       out_free,
    output lane_cmd_t                  cmd,
    output logic [$clog2(PROCS)-1:0]   idx,
    output logic                       res_load,
    output rsp_t                       res
);

    localparam int IDX_W = $clog2(PROCS);

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   scan_next;
    logic [IDX_W-1:0]   proc_reg;
    logic               proc_ok_reg;
    logic               granted_reg;
    logic               granted_next;
    logic               progress_reg;
    logic               progress_next;
    logic [RANK_W-1:0]  done_reg;
    logic [RANK_W-1:0]  done_next;
    logic [RANK_W-1:0]  rank_reg [PROCS];
    logic [RANK_W-1:0]  rank_pad [MAX_PROCS];
    logic               clear_ranks;
    logic               hit;
    logic               last;
    logic               accept;
    logic               in_proc_ok;

    assign accept     = in_valid && in_ready;
    assign in_proc_ok = {1'b0, in_data.proc} < (PROC_W + 1)'(PROCS);
    assign hit        = (rank_reg[scan_reg] == '0) && (&fits_vec);
    assign last       = scan_reg == IDX_W'(PROCS - 1);

    always_comb
    begin
        case (state_reg)
            ST_IDLE: idx = in_data.proc[IDX_W-1:0];
            ST_REQ:  idx = proc_reg;
            default: idx = scan_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        granted_next  = granted_reg;
        progress_next = progress_reg;
        done_next     = done_reg;
        clear_ranks   = 1'b0;
        cmd           = '0;
        in_ready      = 1'b0;
        res_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_data.kind)
                        KIND_ROW:   cmd.wr_row   = in_proc_ok;
                        KIND_AVAIL: cmd.wr_avail = 1'b1;
                        KIND_CHECK: state_next   = ST_START;
                        KIND_REQ:
                        begin
                            cmd.latch_req = 1'b1;
                            state_next    = ST_REQ;
                        end
                        default:    state_next   = ST_IDLE;
                    endcase
                end
            end
            ST_REQ:
            begin
                clear_ranks = 1'b1;
                done_next   = '0;
                if (proc_ok_reg && (&ok_vec))
                begin
                    cmd.apply_req = 1'b1;
                    state_next    = ST_START;
                end
                else
                begin
                    granted_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_START:
            begin
                cmd.load_work = 1'b1;
                clear_ranks   = 1'b1;
                granted_next  = 1'b1;
                done_next     = '0;
                scan_next     = '0;
                progress_next = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.add_work = hit;
                done_next    = done_reg + RANK_W'(hit);
                if (done_next == RANK_W'(PROCS))
                begin
                    state_next = ST_DONE;
                end
                else if (last)
                begin
                    scan_next     = '0;
                    progress_next = 1'b0;
                    if (!(progress_reg || hit))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    scan_next     = scan_reg + 1'b1;
                    progress_next = progress_reg || hit;
                end
            end
            ST_DONE:
            begin
                res_load = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_reg     <= '0;
            granted_reg  <= 1'b0;
            progress_reg <= 1'b0;
            done_reg     <= '0;
            for (int p = 0; p < PROCS; p++)
            begin
                rank_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            granted_reg  <= granted_next;
            progress_reg <= progress_next;
            done_reg     <= done_next;
            if (clear_ranks)
            begin
                for (int p = 0; p < PROCS; p++)
                begin
                    rank_reg[p] <= '0;
                end
            end
            else if (state_reg == ST_SCAN && hit)
            begin
                rank_reg[scan_reg] <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            proc_reg    <= in_data.proc[IDX_W-1:0];
            proc_ok_reg <= in_proc_ok;
        end
    end

    for (genvar p = 0; p < MAX_PROCS; p++)
    begin : g_rank
        if (p < PROCS)
        begin : g_used
            assign rank_pad[p] = rank_reg[p];
        end
        else
        begin : g_unused
            assign rank_pad[p] = '0;
        end
    end

    always_comb
    begin
        res         = '0;
        res.granted = granted_reg;
        res.safe    = done_reg == RANK_W'(PROCS);
        res.rank_0  = rank_pad[0];
        res.rank_1  = rank_pad[1];
        res.rank_2  = rank_pad[2];
        res.rank_3  = rank_pad[3];
    end

endmodule

FILE: hdl/bankers_safety_check.sv
// ----------------------------------------------------------------------------
// bankers_safety_check
// Deadlock-avoidance checker using the banker's algorithm over a table of
// process allocations and maximum claims and an availability vector.
//
// Usage:
//   req_ch carries one request per handshake: a row write, an availability
//   write, a safety check, or a resource request followed by a check.
//   rsp_ch returns one result for checks and resource requests, none for
//   writes. Requests are handled one at a time.
//   Row and availability writes are done when taken in the idle state. A
//   safety check loads the working counts, then the scan compares one process row per
//   cycle in all resource lanes at once, and repeats the pass over all rows
//   until every process finished or a pass finishes none. A resource request
//   first makes its grant decision and applies it before the check; a refused
//   request returns without a check.
//   The result sits in an output register, so the next request is taken
//   while it waits; a further result waits in the sequencer until the
//   register is taken.
//   Reset clears all tables, availability and the output valid flag.
// ----------------------------------------------------------------------------
module bankers_safety_check
    import bsc_pkg::*;
#(
    parameter int PROCS = 4,
    parameter int RES   = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    bsc_req_if.sink     req_ch,
    bsc_rsp_if.source   rsp_ch
);

    localparam int IDX_W  = $clog2(PROCS);
    localparam int WORK_W = $clog2(255 * (PROCS + 1) + 1);

    lane_cmd_t          cmd;
    logic [IDX_W-1:0]   idx;
    logic [RES-1:0]     fits_vec;
    logic [RES-1:0]     ok_vec;
    logic               out_free;
    logic               res_load;
    rsp_t               res;
    logic               rsp_valid_reg;
    rsp_t               rsp_data_reg;
    logic [AMT_W-1:0]   amt_arr [MAX_RES];
    logic [AMT_W-1:0]   clm_arr [MAX_RES];

    assign amt_arr[0] = req_ch.data.amount_0;
    assign amt_arr[1] = req_ch.data.amount_1;
    assign amt_arr[2] = req_ch.data.amount_2;
    assign clm_arr[0] = req_ch.data.claim_0;
    assign clm_arr[1] = req_ch.data.claim_1;
    assign clm_arr[2] = req_ch.data.claim_2;

    assign out_free = !rsp_valid_reg || rsp_ch.ready;

    bsc_ctrl #(
        .PROCS (PROCS),
        .RES   (RES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_ch.valid),
        .in_data  (req_ch.data),
        .in_ready (req_ch.ready),
        .fits_vec (fits_vec),
        .ok_vec   (ok_vec),
        .out_free (out_free),
        .cmd      (cmd),
        .idx      (idx),
        .res_load (res_load),
        .res      (res)
    );

    for (genvar r = 0; r < RES; r++)
    begin : g_lane
        bsc_lane #(
            .PROCS  (PROCS),
            .WORK_W (WORK_W)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .idx    (idx),
            .amt    (amt_arr[r]),
            .clm    (clm_arr[r]),
            .fits   (fits_vec[r]),
            .req_ok (ok_vec[r])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ch.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp_ch.valid = rsp_valid_reg;
    assign rsp_ch.data  = rsp_data_reg;

endmodule

FILE: hdl/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks on the result channel of the banker's safety checker,
// bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker
    import bsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  rsp_valid,
    input  logic  rsp_ready,
    input  rsp_t  rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.granted |->
            !rsp_data.safe && rsp_data.rank_0 == '0 && rsp_data.rank_1 == '0 &&
            rsp_data.rank_2 == '0 && rsp_data.rank_3 == '0)
        else $error("refused request carries check data");

    a_safe_granted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.safe |-> rsp_data.granted)
        else $error("safe result without grant");

    a_safe_ranked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.safe |-> rsp_data.rank_0 != '0 && rsp_data.rank_1 != '0)
        else $error("safe result with unranked process");

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_ch.valid),
    .rsp_ready (rsp_ch.ready),
    .rsp_data  (rsp_ch.data)
);

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the banker's safety checker. Requests go in over
// the valid/ready request channel. A mirror of the allocation, claim and
// availability tables predicts each verdict, and every returned result is
// compared field by field with the oldest verdict still pending. Directed
// corner cases come first, then random scenarios under three idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import bsc_pkg::*;

    localparam int PROCS       = 4;
    localparam int RES         = 3;
    localparam int TAIL_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n;

    bsc_req_if req_ch ();
    bsc_rsp_if rsp_ch ();

    bankers_safety_check #(
        .PROCS (PROCS),
        .RES   (RES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .rsp_ch (rsp_ch)
    );

    logic [AMT_W-1:0] alloc_mirror [PROCS][RES];
    logic [AMT_W-1:0] claim_mirror [PROCS][RES];
    logic [AMT_W-1:0] avail_mirror [RES];

    rsp_t        pending_verdicts [$];
    int unsigned mismatch_count = 0;
    int unsigned requests_sent  = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned snk_idle_pct   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
        else
        begin
            rsp_ch.ready <= 1'b0;
        end
    end

    // banker's safety scan over the mirrored tables
    function automatic rsp_t safety_verdict();
        int unsigned work [RES];
        int unsigned rank [PROCS];
        int unsigned done;
        int unsigned need;
        bit          progress;
        bit          fits;
        rsp_t        v;
        for (int r = 0; r < RES; r++)
        begin
            work[r] = avail_mirror[r];
        end
        for (int p = 0; p < PROCS; p++)
        begin
            rank[p] = 0;
        end
        done     = 0;
        progress = 1'b1;
        while (progress && done < PROCS)
        begin
            progress = 1'b0;
            for (int p = 0; p < PROCS; p++)
            begin
                if (rank[p] == 0)
                begin
                    fits = 1'b1;
                    for (int r = 0; r < RES; r++)
                    begin
                        need = (claim_mirror[p][r] > alloc_mirror[p][r]) ?
                               claim_mirror[p][r] - alloc_mirror[p][r] : 0;
                        if (need > work[r])
                        begin
                            fits = 1'b0;
                        end
                    end
                    if (fits)
                    begin
                        for (int r = 0; r < RES; r++)
                        begin
                            work[r] += alloc_mirror[p][r];
                        end
                        done++;
                        rank[p]  = done;
                        progress = 1'b1;
                    end
                end
            end
        end
        v         = '0;
        v.granted = 1'b1;
        v.safe    = (done == PROCS);
        v.rank_0  = rank[0][RANK_W-1:0];
        v.rank_1  = rank[1][RANK_W-1:0];
        v.rank_2  = rank[2][RANK_W-1:0];
        v.rank_3  = rank[3][RANK_W-1:0];
        return v;
    endfunction

    function automatic void predict_request(input req_t item);
        logic [AMT_W-1:0] amt [RES];
        logic [AMT_W-1:0] clm [RES];
        bit               ok;
        amt[0] = item.amount_0;
        amt[1] = item.amount_1;
        amt[2] = item.amount_2;
        clm[0] = item.claim_0;
        clm[1] = item.claim_1;
        clm[2] = item.claim_2;
        case (item.kind)
            KIND_ROW:
            begin
                if (int'(item.proc) < PROCS)
                begin
                    for (int r = 0; r < RES; r++)
                    begin
                        alloc_mirror[item.proc][r] = amt[r];
                        claim_mirror[item.proc][r] = clm[r];
                    end
                end
            end
            KIND_AVAIL:
            begin
                for (int r = 0; r < RES; r++)
                begin
                    avail_mirror[r] = amt[r];
                end
            end
            KIND_CHECK:
            begin
                pending_verdicts.push_back(safety_verdict());
            end
            default:
            begin
                ok = (int'(item.proc) < PROCS);
                if (ok)
                begin
                    for (int r = 0; r < RES; r++)
                    begin
                        if (amt[r] > avail_mirror[r])
                        begin
                            ok = 1'b0;
                        end
                        if ({1'b0, alloc_mirror[item.proc][r]} + {1'b0, amt[r]} > 9'd255)
                        begin
                            ok = 1'b0;
                        end
                    end
                end
                if (!ok)
                begin
                    pending_verdicts.push_back(rsp_t'('0));
                end
                else
                begin
                    for (int r = 0; r < RES; r++)
                    begin
                        avail_mirror[r]            = avail_mirror[r] - amt[r];
                        alloc_mirror[item.proc][r] = alloc_mirror[item.proc][r] + amt[r];
                    end
                    pending_verdicts.push_back(safety_verdict());
                end
            end
        endcase
    endfunction

    function automatic req_t make_req(input kind_t kind, input int unsigned proc,
                                      input int unsigned a0, input int unsigned a1,
                                      input int unsigned a2, input int unsigned c0,
                                      input int unsigned c1, input int unsigned c2);
        req_t item;
        item.kind     = kind;
        item.proc     = proc[PROC_W-1:0];
        item.amount_0 = a0[AMT_W-1:0];
        item.amount_1 = a1[AMT_W-1:0];
        item.amount_2 = a2[AMT_W-1:0];
        item.claim_0  = c0[AMT_W-1:0];
        item.claim_1  = c1[AMT_W-1:0];
        item.claim_2  = c2[AMT_W-1:0];
        return item;
    endfunction

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_req(input req_t item);
        bit taken;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (req_ch.ready === 1'b1);
            @(posedge clk);
        end
        predict_request(item);
        requests_sent++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge clk)
    begin : result_checker
        rsp_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none actual %p",
                         $time, rsp_ch.data);
                mismatch_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("granted", want.granted, rsp_ch.data.granted);
                check_field("safe", want.safe, rsp_ch.data.safe);
                check_field("rank_0", want.rank_0, rsp_ch.data.rank_0);
                check_field("rank_1", want.rank_1, rsp_ch.data.rank_1);
                check_field("rank_2", want.rank_2, rsp_ch.data.rank_2);
                check_field("rank_3", want.rank_3, rsp_ch.data.rank_3);
            end
        end
    end

    task automatic test_reset_state();
        send_req(make_req(KIND_CHECK, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // claim below allocation on p0, full claim on p1
    task automatic test_row_extremes();
        send_req(make_req(KIND_AVAIL, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_ROW, 0, 255, 255, 255, 0, 0, 0));
        send_req(make_req(KIND_ROW, 1, 0, 0, 0, 255, 255, 255));
        send_req(make_req(KIND_ROW, 2, 1, 2, 3, 10, 20, 30));
        send_req(make_req(KIND_ROW, 3, 0, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_CHECK, 3, 0, 0, 0, 0, 0, 0));
    endtask

    // allocation overflow, availability shortfall, zero and full requests
    task automatic test_request_limits();
        send_req(make_req(KIND_AVAIL, 0, 255, 255, 255, 0, 0, 0));
        send_req(make_req(KIND_REQ, 0, 1, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_REQ, 2, 254, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_REQ, 3, 255, 255, 255, 0, 0, 0));
        send_req(make_req(KIND_REQ, 1, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_unsafe_state();
        for (int p = 0; p < PROCS; p++)
        begin
            send_req(make_req(KIND_ROW, p, 0, 0, 0, 255, 255, 255));
        end
        send_req(make_req(KIND_AVAIL, 0, 254, 254, 254, 0, 0, 0));
        send_req(make_req(KIND_CHECK, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_AVAIL, 0, 255, 255, 255, 0, 0, 0));
        send_req(make_req(KIND_CHECK, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // each pass finishes one process, from the last index back to the first
    task automatic test_multi_pass();
        for (int p = 0; p < PROCS; p++)
        begin
            send_req(make_req(KIND_ROW, p, 1, 1, 1, PROCS - p, PROCS - p, PROCS - p));
        end
        send_req(make_req(KIND_AVAIL, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_req(KIND_CHECK, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic random_scenario();
        int unsigned scale;
        int unsigned a [RES];
        int unsigned c [RES];
        int unsigned need;
        int unsigned pick;
        int unsigned proc;
        case ($urandom_range(0, 2))
            0:       scale = 3;
            1:       scale = 15;
            default: scale = 255;
        endcase
        for (int p = 0; p < PROCS; p++)
        begin
            for (int r = 0; r < RES; r++)
            begin
                a[r] = $urandom_range(0, scale);
                if ($urandom_range(0, 9) == 0)
                begin
                    c[r] = $urandom_range(0, 255);
                end
                else
                begin
                    c[r] = a[r] + $urandom_range(0, scale);
                    if (c[r] > 255)
                    begin
                        c[r] = 255;
                    end
                end
            end
            send_req(make_req(KIND_ROW, p, a[0], a[1], a[2], c[0], c[1], c[2]));
        end
        send_req(make_req(KIND_AVAIL, $urandom, $urandom_range(0, scale),
                          $urandom_range(0, scale), $urandom_range(0, scale),
                          $urandom, $urandom, $urandom));
        repeat ($urandom_range(2, 8))
        begin
            pick = $urandom_range(0, 99);
            proc = $urandom_range(0, PROCS - 1);
            if (pick < 55)
            begin
                for (int r = 0; r < RES; r++)
                begin
                    need = (claim_mirror[proc][r] > alloc_mirror[proc][r]) ?
                           claim_mirror[proc][r] - alloc_mirror[proc][r] : 0;
                    a[r] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, scale) :
                           $urandom_range(0, need);
                end
                send_req(make_req(KIND_REQ, proc, a[0], a[1], a[2],
                                  $urandom, $urandom, $urandom));
            end
            else if (pick < 80)
            begin
                send_req(make_req(KIND_CHECK, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom));
            end
            else if (pick < 90)
            begin
                send_req(make_req(KIND_AVAIL, $urandom, $urandom_range(0, scale),
                                  $urandom_range(0, scale), $urandom_range(0, scale),
                                  $urandom, $urandom, $urandom));
            end
            else
            begin
                send_req(make_req(kind_t'($urandom_range(0, 3)), $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom, $urandom));
            end
        end
    endtask

    task automatic test_random_mix(input int unsigned count);
        int unsigned target;
        target = requests_sent + count;
        while (requests_sent < target)
        begin
            random_scenario();
        end
    endtask

    initial
    begin
        for (int p = 0; p < PROCS; p++)
        begin
            for (int r = 0; r < RES; r++)
            begin
                alloc_mirror[p][r] = '0;
                claim_mirror[p][r] = '0;
            end
        end
        for (int r = 0; r < RES; r++)
        begin
            avail_mirror[r] = '0;
        end
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 15;
        snk_idle_pct = 59;
        test_reset_state();
        test_row_extremes();
        test_request_limits();
        test_unsafe_state();
        test_multi_pass();
        test_random_mix(400);

        src_idle_pct = 59;
        snk_idle_pct = 15;
        test_random_mix(400);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_mix(400);

        req_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
